### src/basr_pkg.sv
package basr_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;
  localparam int TIMER_BITS     = 20;
  localparam int ELAPSED_BITS   = 24;
  localparam int HALF_BITS      = 8;
  localparam int RST_HIGH_BITS  = 16;
  localparam int SETTLE_BITS    = 20;
  localparam int TIMEOUT_BITS   = 24;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RESET_HIGH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SETTLE      = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT     = 2'd3;

  localparam logic [HALF_BITS-1:0]     HALF_PERIOD_RESET = 8'd5;
  localparam logic [RST_HIGH_BITS-1:0] RESET_HIGH_RESET  = 16'd1000;
  localparam logic [SETTLE_BITS-1:0]   SETTLE_RESET      = 20'd500000;
  localparam logic [TIMEOUT_BITS-1:0]  TIMEOUT_RESET     = 24'd1000000;

  typedef struct packed {
    logic start_read;
    logic dout_level;
  } in_t;

  typedef struct packed {
    logic                   sck_level;
    logic                   busy_res;
    logic                   done_res;
    logic                   success;
    logic [SAMPLE_BITS-1:0] sample_value;
  } out_t;

  typedef struct packed {
    logic                      write;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_wr_t;

endpackage

### src/basr_core.sv
module basr_core #(
  parameter int DATA_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  basr_pkg::cfg_wr_t cfg,
  input  logic             accept,
  input  basr_pkg::in_t    item,
  output basr_pkg::out_t   result
);

  localparam int CNT_BITS  = $clog2(DATA_BITS + 1);
  localparam int WIDE_BITS = (DATA_BITS > basr_pkg::SAMPLE_BITS) ? DATA_BITS
                                                                  : basr_pkg::SAMPLE_BITS;
  localparam logic [DATA_BITS-1:0] TOP_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_RST_HIGH   = 3'd1;
  localparam logic [2:0] PH_RST_SETTLE = 3'd2;
  localparam logic [2:0] PH_WAIT_READY = 3'd3;
  localparam logic [2:0] PH_CLK_HIGH   = 3'd4;
  localparam logic [2:0] PH_CLK_LOW    = 3'd5;
  localparam logic [2:0] PH_EXTRA_HIGH = 3'd6;

  logic [basr_pkg::HALF_BITS-1:0]     half_period;
  logic [basr_pkg::RST_HIGH_BITS-1:0] reset_high;
  logic [basr_pkg::SETTLE_BITS-1:0]   settle;
  logic [basr_pkg::TIMEOUT_BITS-1:0]  timeout;

  logic                               initialized, initialized_next;
  logic [2:0]                         phase, phase_next;
  logic [basr_pkg::TIMER_BITS-1:0]    phase_timer, phase_timer_next;
  logic [basr_pkg::ELAPSED_BITS-1:0]  elapsed, elapsed_next;
  logic [CNT_BITS-1:0]                bit_count, bit_count_next;
  logic [DATA_BITS-1:0]               shift_value, shift_value_next;
  logic [basr_pkg::SAMPLE_BITS-1:0]   last_value, last_value_next;
  logic                               done, ok;

  logic                               half_over;
  logic [WIDE_BITS-1:0]               flipped;

  assign half_over = phase_timer >= basr_pkg::TIMER_BITS'(half_period);
  assign flipped   = WIDE_BITS'(shift_value ^ TOP_BIT);

  always_comb begin
    initialized_next = initialized;
    phase_next       = phase;
    phase_timer_next = phase_timer;
    elapsed_next     = elapsed;
    bit_count_next   = bit_count;
    shift_value_next = shift_value;
    last_value_next  = last_value;
    done             = 1'b0;
    ok               = 1'b0;
    if (phase == PH_IDLE) begin
      if (item.start_read) begin
        elapsed_next     = '0;
        phase_next       = initialized ? PH_WAIT_READY : PH_RST_HIGH;
        phase_timer_next = basr_pkg::TIMER_BITS'(1);
      end
    end else begin
      if (elapsed != '1) begin
        elapsed_next = elapsed + basr_pkg::ELAPSED_BITS'(1);
      end
      unique case (phase)
        PH_RST_HIGH: begin
          if (phase_timer >= basr_pkg::TIMER_BITS'(reset_high)) begin
            phase_next       = PH_RST_SETTLE;
            phase_timer_next = basr_pkg::TIMER_BITS'(1);
          end else begin
            phase_timer_next = phase_timer + basr_pkg::TIMER_BITS'(1);
          end
        end
        PH_RST_SETTLE: begin
          if (phase_timer >= basr_pkg::TIMER_BITS'(settle)) begin
            initialized_next = 1'b1;
            phase_next       = PH_WAIT_READY;
            phase_timer_next = basr_pkg::TIMER_BITS'(1);
          end else begin
            phase_timer_next = phase_timer + basr_pkg::TIMER_BITS'(1);
          end
        end
        PH_WAIT_READY: begin
          if (!item.dout_level) begin
            bit_count_next   = '0;
            shift_value_next = '0;
            phase_next       = PH_CLK_HIGH;
            phase_timer_next = basr_pkg::TIMER_BITS'(1);
          end else if (elapsed_next >= timeout) begin
            // ready timeout, last value kept
            done             = 1'b1;
            phase_next       = PH_IDLE;
            phase_timer_next = '0;
          end
        end
        PH_CLK_HIGH: begin
          if (half_over) begin
            // sample on the falling edge tick
            shift_value_next = {shift_value[DATA_BITS-2:0], item.dout_level};
            bit_count_next   = bit_count + CNT_BITS'(1);
            phase_next       = PH_CLK_LOW;
            phase_timer_next = basr_pkg::TIMER_BITS'(1);
          end else begin
            phase_timer_next = phase_timer + basr_pkg::TIMER_BITS'(1);
          end
        end
        PH_CLK_LOW: begin
          if (half_over) begin
            phase_next       = (bit_count >= CNT_BITS'(DATA_BITS)) ? PH_EXTRA_HIGH
                                                                   : PH_CLK_HIGH;
            phase_timer_next = basr_pkg::TIMER_BITS'(1);
          end else begin
            phase_timer_next = phase_timer + basr_pkg::TIMER_BITS'(1);
          end
        end
        PH_EXTRA_HIGH: begin
          if (half_over) begin
            last_value_next  = flipped[basr_pkg::SAMPLE_BITS-1:0];
            done             = 1'b1;
            ok               = 1'b1;
            phase_next       = PH_IDLE;
            phase_timer_next = '0;
          end else begin
            phase_timer_next = phase_timer + basr_pkg::TIMER_BITS'(1);
          end
        end
        default: begin
          phase_next       = PH_IDLE;
          phase_timer_next = '0;
        end
      endcase
    end
  end

  always_comb begin
    result.sck_level    = (phase_next == PH_RST_HIGH) || (phase_next == PH_CLK_HIGH) ||
                          (phase_next == PH_EXTRA_HIGH);
    result.busy_res     = phase_next != PH_IDLE;
    result.done_res     = done;
    result.success      = ok;
    result.sample_value = last_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= basr_pkg::HALF_PERIOD_RESET;
      reset_high  <= basr_pkg::RESET_HIGH_RESET;
      settle      <= basr_pkg::SETTLE_RESET;
      timeout     <= basr_pkg::TIMEOUT_RESET;
      initialized <= 1'b0;
      phase       <= PH_IDLE;
      phase_timer <= '0;
      elapsed     <= '0;
      bit_count   <= '0;
      shift_value <= '0;
      last_value  <= '0;
    end else begin
      if (cfg.write) begin
        unique case (cfg.index)
          basr_pkg::CFG_HALF_PERIOD: half_period <= cfg.data[basr_pkg::HALF_BITS-1:0];
          basr_pkg::CFG_RESET_HIGH:  reset_high  <= cfg.data[basr_pkg::RST_HIGH_BITS-1:0];
          basr_pkg::CFG_SETTLE:      settle      <= cfg.data[basr_pkg::SETTLE_BITS-1:0];
          basr_pkg::CFG_TIMEOUT:     timeout     <= cfg.data[basr_pkg::TIMEOUT_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        initialized <= initialized_next;
        phase       <= phase_next;
        phase_timer <= phase_timer_next;
        elapsed     <= elapsed_next;
        bit_count   <= bit_count_next;
        shift_value <= shift_value_next;
        last_value  <= last_value_next;
      end
    end
  end

endmodule

### src/basr_skid.sv
module basr_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  basr_pkg::out_t push_item,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output basr_pkg::out_t out_item
);

  logic           skid_valid;
  basr_pkg::out_t skid_item;
  logic           take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      // output register is held, park the item
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (push) begin
        out_item <= push_item;
      end
    end else if (push) begin
      skid_item <= push_item;
    end
  end

endmodule

### src/bridge_adc_serial_reader_unit.sv
// channel   direction  handshake               payload
// cfg       in         cfg_write               cfg_index, cfg_data
// in        in         in_valid / in_stall     in_item (start_read, dout_level)
// out       out        out_valid / out_stall   in_item's result in out_item
//
// one input item (one microsecond tick) per clock while in_stall is low, one result
// item per input item; each result is registered in the output register, or in the
// skid entry while the output is held; in_stall rises only after out_stall has held
// a result; the output register plus one skid entry hold two results
// rst is synchronous: registers go to their defaults, the sequencer goes idle
module bridge_adc_serial_reader_unit #(
  parameter int DATA_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [basr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [basr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  basr_pkg::in_t                       in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output basr_pkg::out_t                      out_item
);

  basr_pkg::cfg_wr_t cfg;
  basr_pkg::out_t    result;
  logic              accept;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;
  assign accept    = in_valid && !in_stall;

  basr_core #(
    .DATA_BITS(DATA_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .accept(accept),
    .item  (in_item),
    .result(result)
  );

  basr_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_item(result),
    .full     (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

### src/basr_checker.sv
module basr_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input basr_pkg::out_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a held result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> !out_item.busy_res && !out_item.sck_level)
    else $error("finishing item not idle with clock low");

  a_success_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.success |-> out_item.done_res)
    else $error("success without done");

  a_idle_sck_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.busy_res |-> !out_item.sck_level)
    else $error("serial clock high while idle");

endmodule

bind bridge_adc_serial_reader_unit basr_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);
